// ===== rtl/osa_pkg.sv =====
// Shared types and constants for the OSA edit distance core.
// Used by every module of the block but osa_ram; depends on nothing.
`default_nettype none

package osa_pkg;

	localparam int MAX_LEN_DEF = 64;
	localparam int DIST_W      = 7;
	localparam int CHAR_W      = 8;
	localparam int RATIO_W     = 8;
	localparam logic [RATIO_W-1:0] RATIO_RESET = 8'd3;

	localparam logic [1:0] OP_APPEND_FIRST  = 2'd0;
	localparam logic [1:0] OP_APPEND_SECOND = 2'd1;
	localparam logic [1:0] OP_COMPUTE       = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GUARD_A,
		ST_GUARD_B,
		ST_INIT,
		ST_ROW_RD,
		ST_ROW_LD,
		ST_CELL_RD,
		ST_CELL_EX,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic first_col;
		logic match;
		logic swap;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/osa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module osa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/osa_cell.sv =====
// Cell update unit: minimum over insert, delete, substitute and swap costs; row index in column 0.
// Depends on osa_pkg for the control struct.
`default_nettype none

module osa_cell #(
	parameter int W = 7
) (
	input  wire osa_pkg::cell_ctl_t ctl,
	input  wire logic [W-1:0]  up,
	input  wire logic [W-1:0]  diag,
	input  wire logic [W-1:0]  left,
	input  wire logic [W-1:0]  trans,
	input  wire logic [W-1:0]  row_idx,
	output logic      [W-1:0]  best
);
	import osa_pkg::*;

	logic [W:0] up1, left1, diag0, diag1, trans1, m;

	always_comb begin
		up1    = {1'b0, up} + (W+1)'(1);
		left1  = {1'b0, left} + (W+1)'(1);
		diag0  = {1'b0, diag};
		diag1  = {1'b0, diag} + (W+1)'(1);
		trans1 = {1'b0, trans} + (W+1)'(1);
		m = up1;
		if (left1 < m) begin
			m = left1;
		end
		if (diag1 < m) begin
			m = diag1;
		end
		if (ctl.match && (diag0 < m)) begin
			m = diag0;
		end
		if (ctl.swap && (trans1 < m)) begin
			m = trans1;
		end
		if (ctl.first_col) begin
			best = row_idx;
		end else begin
			best = m[W-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/osa_edit_distance_core.sv =====
// Top level of the OSA edit distance core: stream ports, sequencer, string and row memories.
// Depends on osa_pkg, osa_ram and osa_cell.
`default_nettype none

// Appends (op 0, op 1) are accepted while a result waits.
// A compute (op 2) is not accepted back to back: the length guard runs through the GUARD_A
// and GUARD_B states on one shared multiplier, then, unless the guard cuts off, row setup
// writes row 0 for columns 0..m, and each of the n rows runs a row read and a row load,
// then a read state and an execute state per cell through the single cell unit and the
// registered-read row memories. The done state hands the result to the output register.
// Characters beyond MAX_LEN per string are dropped and reported on the overflow flag.
module osa_edit_distance_core #(
	parameter int MAX_LEN = osa_pkg::MAX_LEN_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,  // size_ratio_limit
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,    // [7:0] ch
	input  wire logic [1:0] s_tuser,    // [1:0] op
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic      [7:0] m_tdata,    // [6:0] distance, [7] zero
	output logic      [1:0] m_tuser     // [0] ratio_cutoff, [1] overflow
);
	import osa_pkg::*;

	localparam int LEN_W = $clog2(MAX_LEN + 1);
	localparam int CAW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int PW    = LEN_W + RATIO_W;

	state_t state_q, state_d;

	logic [RATIO_W-1:0] ratio_q;
	logic [LEN_W-1:0]   first_len_q, second_len_q;
	logic               dropped_q;
	logic [LEN_W-1:0]   i_q, j_q;
	logic               cut_q;
	logic [LEN_W-1:0]   res_q;
	logic [CHAR_W-1:0]  a_cur_q, a_prev_q, b_prev_q;
	logic [LEN_W-1:0]   diag_q, left_q, p2_d1_q, p2_d2_q;

	logic               out_valid_q;
	logic [DIST_W-1:0]  out_dist_q;
	logic               out_cut_q, out_ovf_q;

	logic               accept, out_load;
	logic               wr_first, wr_second, row_we;
	logic [LEN_W-1:0]   im1, jm1, cur, prev_rd, prev2_rd, row_wdata, row2_wdata;
	logic [CHAR_W-1:0]  a_rd, b_rd;
	logic [LEN_W-1:0]   mul_a, mul_b;
	logic [PW-1:0]      prod;
	logic               below;
	logic               cut_all;
	logic [LEN_W-1:0]   longer;
	logic               last_col, last_row;
	cell_ctl_t          ctl;
	logic [DIST_W+LEN_W-1:0] dist_ext;

	assign accept    = s_tvalid && s_tready;
	assign im1       = i_q - LEN_W'(1);
	assign jm1       = j_q - LEN_W'(1);
	assign last_col  = (j_q == second_len_q);
	assign last_row  = (i_q == first_len_q);
	assign longer    = (first_len_q > second_len_q) ? first_len_q : second_len_q;

	// shared guard multiplier
	assign mul_a   = (state_q == ST_GUARD_A) ? first_len_q : second_len_q;
	assign mul_b   = (state_q == ST_GUARD_A) ? second_len_q : first_len_q;
	assign prod    = PW'(mul_a) * PW'(ratio_q);
	assign below   = prod < PW'(mul_b);
	assign cut_all = cut_q || below;

	assign wr_first  = accept && (s_tuser == OP_APPEND_FIRST) &&
		(first_len_q < LEN_W'(MAX_LEN));
	assign wr_second = accept && (s_tuser == OP_APPEND_SECOND) &&
		(second_len_q < LEN_W'(MAX_LEN));

	assign ctl.first_col = (j_q == '0);
	assign ctl.match     = (a_cur_q == b_rd);
	assign ctl.swap      = (i_q >= LEN_W'(2)) && (j_q >= LEN_W'(2)) &&
		(a_prev_q == b_rd) && (a_cur_q == b_prev_q);

	assign row_wdata  = (state_q == ST_INIT) ? j_q : cur;
	assign row2_wdata = (state_q == ST_INIT) ? '0 : prev_rd;

	osa_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_first (
		.clk   (clk),
		.we    (wr_first),
		.waddr (first_len_q[CAW-1:0]),
		.wdata (s_tdata),
		.raddr (im1[CAW-1:0]),
		.rdata (a_rd)
	);

	osa_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_second (
		.clk   (clk),
		.we    (wr_second),
		.waddr (second_len_q[CAW-1:0]),
		.wdata (s_tdata),
		.raddr (jm1[CAW-1:0]),
		.rdata (b_rd)
	);

	osa_ram #(.WIDTH(LEN_W), .DEPTH(MAX_LEN + 1)) u_row_prev (
		.clk   (clk),
		.we    (row_we),
		.waddr (j_q),
		.wdata (row_wdata),
		.raddr (j_q),
		.rdata (prev_rd)
	);

	osa_ram #(.WIDTH(LEN_W), .DEPTH(MAX_LEN + 1)) u_row_prev_two (
		.clk   (clk),
		.we    (row_we),
		.waddr (j_q),
		.wdata (row2_wdata),
		.raddr (j_q),
		.rdata (prev2_rd)
	);

	osa_cell #(.W(LEN_W)) u_cell (
		.ctl     (ctl),
		.up      (prev_rd),
		.diag    (diag_q),
		.left    (left_q),
		.trans   (p2_d2_q),
		.row_idx (i_q),
		.best    (cur)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		out_load = 1'b0;
		row_we   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && (s_tuser == OP_COMPUTE)) begin
					state_d = ST_GUARD_A;
				end
			end
			ST_GUARD_A: begin
				state_d = ST_GUARD_B;
			end
			ST_GUARD_B: begin
				state_d = cut_all ? ST_DONE : ST_INIT;
			end
			ST_INIT: begin
				row_we = 1'b1;
				if (last_col) begin
					state_d = (first_len_q == '0) ? ST_DONE : ST_ROW_RD;
				end
			end
			ST_ROW_RD: begin
				state_d = ST_ROW_LD;
			end
			ST_ROW_LD: begin
				state_d = ST_CELL_RD;
			end
			ST_CELL_RD: begin
				state_d = ST_CELL_EX;
			end
			ST_CELL_EX: begin
				row_we = 1'b1;
				if (!last_col) begin
					state_d = ST_CELL_RD;
				end else if (last_row) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_ROW_RD;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q      <= RATIO_RESET;
			first_len_q  <= '0;
			second_len_q <= '0;
			dropped_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				ratio_q <= cfg_wdata;
			end
			if (wr_first) begin
				first_len_q <= first_len_q + LEN_W'(1);
			end
			if (wr_second) begin
				second_len_q <= second_len_q + LEN_W'(1);
			end
			if (accept && ((s_tuser == OP_APPEND_FIRST && !wr_first) ||
				(s_tuser == OP_APPEND_SECOND && !wr_second))) begin
				dropped_q <= 1'b1;
			end
			if (out_load) begin
				first_len_q  <= '0;
				second_len_q <= '0;
				dropped_q    <= 1'b0;
				out_valid_q  <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign dist_ext = {{DIST_W{1'b0}}, res_q};

	always_ff @(posedge clk) begin
		case (state_q)
			ST_GUARD_A: begin
				cut_q <= below;
			end
			ST_GUARD_B: begin
				cut_q <= cut_all;
				res_q <= cut_all ? longer : second_len_q;
				j_q   <= '0;
			end
			ST_INIT: begin
				if (!last_col) begin
					j_q <= j_q + LEN_W'(1);
				end
				i_q <= LEN_W'(1);
			end
			ST_ROW_LD: begin
				a_prev_q <= a_cur_q;
				a_cur_q  <= a_rd;
				j_q      <= '0;
			end
			ST_CELL_EX: begin
				diag_q   <= prev_rd;
				left_q   <= cur;
				res_q    <= cur;
				b_prev_q <= b_rd;
				p2_d1_q  <= prev2_rd;
				p2_d2_q  <= p2_d1_q;
				if (!last_col) begin
					j_q <= j_q + LEN_W'(1);
				end else begin
					i_q <= i_q + LEN_W'(1);
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_dist_q <= dist_ext[DIST_W-1:0];
			out_cut_q  <= cut_q;
			out_ovf_q  <= dropped_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_dist_q};
	assign m_tuser  = {out_ovf_q, out_cut_q};

endmodule

`default_nettype wire

// ===== rtl/osa_checker.sv =====
// Port-level checks for the OSA edit distance core, bound to its top level.
// Depends on osa_pkg and the port list of osa_edit_distance_core.
`default_nettype none

module osa_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic [1:0] s_tuser,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic [1:0] m_tuser
);
	import osa_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a compute transfer keeps the input side busy through the guard
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == OP_COMPUTE) |-> ##1 !s_tready ##1 !s_tready)
		else $error("input accepted during compute");

	// a new result only follows a busy cycle
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without compute");

endmodule

bind osa_edit_distance_core osa_checker u_osa_checker (.*);

`default_nettype wire

// ===== test/osa_edit_distance_checker.sv =====
`timescale 1ns / 100ps
// Checker for osa_edit_distance_core: watches the config port and both stream channels.
// Predicts each distance result and compares it with the output transfers. Depends on osa_pkg.
module osa_edit_distance_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic       s_tvalid,
	input  wire logic       s_tready,
	input  wire logic [7:0] s_tdata,
	input  wire logic [1:0] s_tuser,
	input  wire logic       m_tvalid,
	input  wire logic       m_tready,
	input  wire logic [7:0] m_tdata,
	input  wire logic [1:0] m_tuser,
	output int              mismatch_count,
	output int              results_outstanding
);
	import osa_pkg::*;

	localparam int CAP = MAX_LEN_DEF;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              ratio_cutoff;
		logic              overflow;
	} dist_result_t;

	logic [CHAR_W-1:0]  str_a [CAP];
	logic [CHAR_W-1:0]  str_b [CAP];
	int                 len_a;
	int                 len_b;
	logic               dropped;
	logic [RATIO_W-1:0] ratio;
	dist_result_t       pending_distances [$];

	// restricted Damerau-Levenshtein over the stored prefixes
	function automatic logic [DIST_W-1:0] align_cost(input int n, input int m);
		int row1 [CAP+1];
		int row2 [CAP+1];
		int cur  [CAP+1];
		int best;
		for (int j = 0; j <= m; j++) begin
			row1[j] = j;
			row2[j] = 0;
		end
		for (int i = 1; i <= n; i++) begin
			cur[0] = i;
			for (int j = 1; j <= m; j++) begin
				best = row1[j] + 1;
				if (cur[j-1] + 1 < best)
					best = cur[j-1] + 1;
				if (row1[j-1] + ((str_a[i-1] == str_b[j-1]) ? 0 : 1) < best)
					best = row1[j-1] + ((str_a[i-1] == str_b[j-1]) ? 0 : 1);
				if (i >= 2 && j >= 2) begin
					if (str_a[i-2] == str_b[j-1] && str_a[i-1] == str_b[j-2] &&
					    row2[j-2] + 1 < best)
						best = row2[j-2] + 1;
				end
				cur[j] = best;
			end
			row2 = row1;
			row1 = cur;
		end
		return row1[m][DIST_W-1:0];
	endfunction

	function automatic dist_result_t predict_compute();
		dist_result_t r;
		int lim;
		int longer;
		lim = int'(ratio);
		longer = (len_a > len_b) ? len_a : len_b;
		r.overflow = dropped;
		if (len_a * lim < len_b || len_b * lim < len_a) begin
			r.ratio_cutoff = 1'b1;
			r.distance = longer[DIST_W-1:0];
		end else begin
			r.ratio_cutoff = 1'b0;
			r.distance = align_cost(len_a, len_b);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		dist_result_t want;
		int errs;
		errs = 0;
		if (!arst_n) begin
			len_a = 0;
			len_b = 0;
			dropped = 1'b0;
			ratio = RATIO_RESET;
			pending_distances.delete();
			mismatch_count <= 0;
			results_outstanding <= 0;
		end else begin
			if (cfg_we)
				ratio = cfg_wdata;
			if (m_tvalid && m_tready) begin
				if (pending_distances.size() == 0) begin
					$display("%0t unexpected result: expected none, %s %0d %0d %0d",
						$time, "got distance, cutoff, overflow",
						m_tdata, m_tuser[0], m_tuser[1]);
					errs++;
				end else begin
					want = pending_distances.pop_front();
					if (m_tdata !== {1'b0, want.distance}) begin
						$display("%0t distance mismatch: expected %0d, got %0d",
							$time, {1'b0, want.distance}, m_tdata);
						errs++;
					end
					if (m_tuser[0] !== want.ratio_cutoff) begin
						$display("%0t ratio_cutoff mismatch: expected %0d, got %0d",
							$time, want.ratio_cutoff, m_tuser[0]);
						errs++;
					end
					if (m_tuser[1] !== want.overflow) begin
						$display("%0t overflow mismatch: expected %0d, got %0d",
							$time, want.overflow, m_tuser[1]);
						errs++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				case (s_tuser)
				OP_APPEND_FIRST: begin
					if (len_a < CAP) begin
						str_a[len_a] = s_tdata;
						len_a++;
					end else
						dropped = 1'b1;
				end
				OP_APPEND_SECOND: begin
					if (len_b < CAP) begin
						str_b[len_b] = s_tdata;
						len_b++;
					end else
						dropped = 1'b1;
				end
				OP_COMPUTE: begin
					pending_distances.push_back(predict_compute());
					len_a = 0;
					len_b = 0;
					dropped = 1'b0;
				end
				default: ;
				endcase
			end
			mismatch_count <= mismatch_count + errs;
			results_outstanding <= pending_distances.size();
		end
	end

endmodule

// ===== test/tb_osa_edit_distance_core.sv =====
`timescale 1ns / 100ps
// Testbench top for osa_edit_distance_core: clock, reset, config writes and stream stimulus.
// Depends on osa_pkg, the core RTL and osa_edit_distance_checker.
module tb_osa_edit_distance_core;
	import osa_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int ITEM_GOAL     = 1250;
	localparam int RUN_LIMIT     = 1000000;
	localparam int HOLD_CYCLES   = 1000;
	localparam int SETTLE_CYCLES = 16;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_we    = 1'b0;
	logic [7:0] cfg_wdata = 8'd0;
	logic       s_tvalid  = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata   = 8'd0;
	logic [1:0] s_tuser   = 2'd0;
	logic       m_tvalid;
	logic       m_tready  = 1'b0;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;

	int mismatch_count;
	int results_outstanding;
	int send_idle_pct = 16;
	int recv_idle_pct = 84;
	int noise_pct     = 0;
	int items_sent    = 0;
	int cycle_count   = 0;
	int hold_cnt      = 0;
	bit hold_req      = 1'b0;

	logic [7:0] load_first [$];
	logic [7:0] load_second [$];

	osa_edit_distance_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	osa_edit_distance_checker dist_check (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.s_tvalid            (s_tvalid),
		.s_tready            (s_tready),
		.s_tdata             (s_tdata),
		.s_tuser             (s_tuser),
		.m_tvalid            (m_tvalid),
		.m_tready            (m_tready),
		.m_tdata             (m_tdata),
		.m_tuser             (m_tuser),
		.mismatch_count      (mismatch_count),
		.results_outstanding (results_outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("FAIL osa_edit_distance_core");
			$finish;
		end
	end

	// result side: one long hold-off once requested, random stalls otherwise
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else if (hold_req && hold_cnt < HOLD_CYCLES) begin
			m_tready <= 1'b0;
			hold_cnt <= hold_cnt + 1;
		end else
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_item(input logic [1:0] op, input logic [7:0] ch);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= ch;
		do @(posedge clk); while (!s_tready);
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (results_outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_ratio(input logic [7:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// loads both strings interleaved in random order, with unused-op noise when enabled, then asks for the distance
	task automatic play_loaded();
		int ia;
		int ib;
		ia = 0;
		ib = 0;
		while (ia < load_first.size() || ib < load_second.size()) begin
			if (noise_pct != 0 && $urandom_range(99) < noise_pct)
				send_item(OP_UNUSED, 8'($urandom));
			else if (ib >= load_second.size() || (ia < load_first.size() && $urandom_range(1))) begin
				send_item(OP_APPEND_FIRST, load_first[ia]);
				ia++;
			end else begin
				send_item(OP_APPEND_SECOND, load_second[ib]);
				ib++;
			end
		end
		send_item(OP_COMPUTE, 8'($urandom));
	endtask

	function automatic logic [7:0] pick_char(input int span, input logic [7:0] base);
		if (span == 0)
			return 8'($urandom);
		return base + 8'($urandom_range(span - 1));
	endfunction

	task automatic build_random();
		int shape;
		int len_first;
		int len_second;
		int span;
		int pos;
		logic [7:0] base;
		logic [7:0] c;
		shape = $urandom_range(99);
		case ($urandom_range(2))
		0: span = 2;
		1: span = 4;
		default: span = 0;
		endcase
		base = 8'($urandom);
		load_first.delete();
		load_second.delete();
		if (shape < 3)
			len_first = $urandom_range(50, 70);
		else if (shape < 10)
			len_first = 0;
		else
			len_first = $urandom_range(1, 8);
		repeat (len_first) load_first.push_back(pick_char(span, base));
		if (shape >= 3 && shape < 35) begin
			len_second = $urandom_range(0, 10);
			repeat (len_second) load_second.push_back(pick_char(span, base));
		end else begin
			load_second = load_first;
			repeat ($urandom_range(3)) begin
				pos = (load_second.size() == 0) ? 0 : $urandom_range(load_second.size() - 1);
				case ($urandom_range(3))
				0: begin
					if (pos + 1 < load_second.size()) begin
						c = load_second[pos];
						load_second[pos] = load_second[pos+1];
						load_second[pos+1] = c;
					end
				end
				1: begin
					if (load_second.size() != 0)
						load_second[pos] = pick_char(span, base);
				end
				2: load_second.insert(pos, pick_char(span, base));
				default: begin
					if (load_second.size() != 0)
						load_second.delete(pos);
				end
				endcase
			end
		end
	endtask

	task automatic run_random(input int goal);
		while (items_sent < goal) begin
			build_random();
			play_loaded();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// both strings empty
		load_first.delete();
		load_second.delete();
		play_loaded();
		send_item(OP_UNUSED, 8'hFF);
		// adjacent swap
		load_first = '{8'h00, 8'hFF};
		load_second = '{8'hFF, 8'h00};
		play_loaded();
		load_first = '{8'hAA};
		load_second = '{8'hAA};
		play_loaded();
		load_first = '{8'h7F};
		load_second = '{8'h80};
		play_loaded();
		// length guard at reset ratio
		load_first = '{8'h55};
		load_second = '{8'h55, 8'h55, 8'h55, 8'h55};
		play_loaded();
		load_first = '{8'h01, 8'h02, 8'h80};
		load_second.delete();
		play_loaded();

		noise_pct = 3;
		write_ratio(8'd0);
		run_random(150);
		write_ratio(8'd255);
		hold_req <= 1'b1;
		run_random(450);
		write_ratio(8'd1);
		run_random(600);
		send_idle_pct = 84;
		recv_idle_pct = 16;
		write_ratio(8'($urandom_range(2, 254)));
		run_random(900);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_ratio(RATIO_RESET);
		run_random(ITEM_GOAL);
		drain();

		if (mismatch_count == 0)
			$display("PASS osa_edit_distance_core");
		else
			$display("FAIL osa_edit_distance_core");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/osa_pkg.sv
rtl/osa_ram.sv
rtl/osa_cell.sv
rtl/osa_edit_distance_core.sv
rtl/osa_checker.sv
test/osa_edit_distance_checker.sv
test/tb_osa_edit_distance_core.sv
